FILE: sv/tcbsg_pkg.sv
// Shared types and constants for the text cell box span generator.
// No dependencies; the front end, span engine and top level refer to it by scoped names.
`default_nettype none

package tcbsg_pkg;

  // Fixed field widths of the channels
  localparam int CORD_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int ROW_OUT_W = 6;
  localparam int COL_OUT_W = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 9;
  localparam int WIDTH_W   = 9;
  localparam int HEIGHT_W  = 7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;

  localparam logic [WIDTH_W-1:0]  RST_SCREEN_WIDTH  = 9'd80;
  localparam logic [HEIGHT_W-1:0] RST_SCREEN_HEIGHT = 7'd25;

  // Command codes
  localparam logic CMD_FILL    = 1'b0;
  localparam logic CMD_OUTLINE = 1'b1;

  // Outline characters
  localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_BAR      = 8'h7C;  // '|'
  localparam logic [CHAR_W-1:0] CH_COMMA    = 8'h2C;  // ',' top left
  localparam logic [CHAR_W-1:0] CH_PERIOD   = 8'h2E;  // '.' top right
  localparam logic [CHAR_W-1:0] CH_BACKTICK = 8'h60;  // '`' bottom left
  localparam logic [CHAR_W-1:0] CH_QUOTE    = 8'h27;  // ''' bottom right

  // Per-box classification handed from the front end to the span engine
  typedef struct packed {
    logic cmd;     // fill or outline
    logic lclip;   // left edge lies off screen
    logic rclip;   // right edge lies off screen
    logic tclip;   // top edge lies off screen
    logic bclip;   // bottom edge lies off screen
    logic lc_x2;   // clipped left column equals the right corner column
    logic rc_x1;   // clipped right column equals the left corner column
    logic mon;     // a middle run exists between left and right
  } box_flags_t;

  localparam int FLAGS_W = $bits(box_flags_t);

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

`default_nettype wire

FILE: sv/tcbsg_queue.sv
// Two-entry queue that decouples the box front end from the span engine.
// Generic payload width; no package dependencies.
`default_nettype none

module tcbsg_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full    = cnt[1];
  assign empty   = (cnt == 2'd0);
  assign rd_data = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/tcbsg_front.sv
// Box front end: takes a command, sorts its corners, culls and clips it.
// Uses tcbsg_pkg for field widths and the box_flags_t classification.
`default_nettype none

module tcbsg_front #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 64,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [tcbsg_pkg::WIDTH_W-1:0]        screen_width,
  input  wire logic [tcbsg_pkg::HEIGHT_W-1:0]       screen_height,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 command,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0]  corner_a_x,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0]  corner_a_y,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0]  corner_b_x,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0]  corner_b_y,
  input  wire logic [tcbsg_pkg::CHAR_W-1:0]         fill_char,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output tcbsg_pkg::box_flags_t                     box_flags,
  output logic [tcbsg_pkg::CHAR_W-1:0]              box_char,
  output logic [CW-1:0]                             box_cx1,
  output logic [CW-1:0]                             box_cx2,
  output logic [RW-1:0]                             box_cy1,
  output logic [RW-1:0]                             box_cy2
);

  localparam int PW  = tcbsg_pkg::CORD_W;
  localparam int EW  = PW + 1;
  localparam int SXW = (CW + 1 > tcbsg_pkg::WIDTH_W) ? CW + 1 : tcbsg_pkg::WIDTH_W;
  localparam int SYW = (RW + 1 > tcbsg_pkg::HEIGHT_W) ? RW + 1 : tcbsg_pkg::HEIGHT_W;
  localparam logic [SXW-1:0] XLIM = SXW'(MAX_COLUMNS);
  localparam logic [SYW-1:0] YLIM = SYW'(MAX_ROWS);

  // Sorted command held between accept and classification
  logic                                  held;
  logic                                  h_cmd;
  logic [tcbsg_pkg::CHAR_W-1:0]          h_char;
  logic signed [PW-1:0]                  h_x1;
  logic signed [PW-1:0]                  h_x2;
  logic signed [PW-1:0]                  h_y1;
  logic signed [PW-1:0]                  h_y2;

  logic [SXW-1:0]        w_ext;
  logic [SYW-1:0]        h_ext;
  logic [SXW-1:0]        xmax_s;
  logic [SYW-1:0]        ymax_s;
  logic [CW-1:0]         xmax;
  logic [RW-1:0]         ymax;
  logic signed [EW-1:0]  xm_e;
  logic signed [EW-1:0]  ym_e;
  logic signed [EW-1:0]  x1_e;
  logic signed [EW-1:0]  x2_e;
  logic signed [EW-1:0]  y1_e;
  logic signed [EW-1:0]  y2_e;
  logic                  cull;
  logic                  done;
  logic [CW:0]           span_w;
  logic                  accept;

  assign accept   = in_valid && in_ready;
  assign done     = held && (cull || !q_full);
  assign in_ready = !held || done;
  assign q_push   = held && !cull && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (done) begin
      held <= 1'b0;
    end
  end

  // Sort the corners on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      h_cmd  <= command;
      h_char <= fill_char;
      h_x1   <= (corner_a_x > corner_b_x) ? corner_b_x : corner_a_x;
      h_x2   <= (corner_a_x > corner_b_x) ? corner_a_x : corner_b_x;
      h_y1   <= (corner_a_y > corner_b_y) ? corner_b_y : corner_a_y;
      h_y2   <= (corner_a_y > corner_b_y) ? corner_a_y : corner_b_y;
    end
  end

  always_comb begin
    // Clamp the screen size into 1..MAX and take the last index
    w_ext = SXW'(screen_width);
    h_ext = SYW'(screen_height);
    if (screen_width == '0) begin
      xmax_s = '0;
    end else if (w_ext > XLIM) begin
      xmax_s = XLIM - SXW'(1);
    end else begin
      xmax_s = w_ext - SXW'(1);
    end
    if (screen_height == '0) begin
      ymax_s = '0;
    end else if (h_ext > YLIM) begin
      ymax_s = YLIM - SYW'(1);
    end else begin
      ymax_s = h_ext - SYW'(1);
    end
    xmax = CW'(xmax_s);
    ymax = RW'(ymax_s);
    xm_e = $signed(EW'(xmax));
    ym_e = $signed(EW'(ymax));
    x1_e = EW'(h_x1);
    x2_e = EW'(h_x2);
    y1_e = EW'(h_y1);
    y2_e = EW'(h_y2);

    cull = h_x2[PW-1] || h_y2[PW-1] || (x1_e > xm_e) || (y1_e > ym_e);

    box_flags.cmd   = h_cmd;
    box_flags.lclip = h_x1[PW-1];
    box_flags.rclip = x2_e > xm_e;
    box_flags.tclip = h_y1[PW-1];
    box_flags.bclip = y2_e > ym_e;

    box_cx1 = box_flags.lclip ? '0 : CW'(h_x1);
    box_cx2 = box_flags.rclip ? xmax : CW'(h_x2);
    box_cy1 = box_flags.tclip ? '0 : RW'(h_y1);
    box_cy2 = box_flags.bclip ? ymax : RW'(h_y2);

    box_flags.lc_x2 = ($signed(EW'(box_cx1)) == x2_e);
    box_flags.rc_x1 = ($signed(EW'(box_cx2)) == x1_e);
    span_w          = (CW + 1)'(box_cx2) - (CW + 1)'(box_cx1);
    box_flags.mon   = span_w >= (CW + 1)'(2);
    box_char        = h_char;
  end

endmodule

`default_nettype wire

FILE: sv/tcbsg_back.sv
// Span engine: walks the rows of one clipped box and registers one span a row.
// Uses tcbsg_pkg for widths, characters, box_flags_t and back_state_t.
`default_nettype none

module tcbsg_back #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 64,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_empty,
  output logic                                     q_pop,
  input  wire tcbsg_pkg::box_flags_t               q_flags,
  input  wire logic [tcbsg_pkg::CHAR_W-1:0]        q_char,
  input  wire logic [CW-1:0]                       q_cx1,
  input  wire logic [CW-1:0]                       q_cx2,
  input  wire logic [RW-1:0]                       q_cy1,
  input  wire logic [RW-1:0]                       q_cy2,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tcbsg_pkg::ROW_OUT_W-1:0]          row,
  output logic [tcbsg_pkg::COL_OUT_W-1:0]          left_col,
  output logic [tcbsg_pkg::COL_OUT_W-1:0]          right_col,
  output logic                                     left_on,
  output logic                                     right_on,
  output logic                                     middle_on,
  output logic [tcbsg_pkg::CHAR_W-1:0]             left_char,
  output logic [tcbsg_pkg::CHAR_W-1:0]             middle_char,
  output logic [tcbsg_pkg::CHAR_W-1:0]             right_char,
  output logic                                     last_span
);

  localparam int ROW_OUT_W = tcbsg_pkg::ROW_OUT_W;
  localparam int COL_OUT_W = tcbsg_pkg::COL_OUT_W;

  tcbsg_pkg::back_state_t state;
  tcbsg_pkg::back_state_t state_next;

  // Active box
  tcbsg_pkg::box_flags_t          flags;
  logic [tcbsg_pkg::CHAR_W-1:0]   fc;
  logic [CW-1:0]                  cx1;
  logic [CW-1:0]                  cx2;
  logic [RW-1:0]                  cy1;
  logic [RW-1:0]                  cy2;
  logic [RW-1:0]                  cur_row;

  logic                           emit;
  logic                           is_top;
  logic                           is_bot;
  logic                           is_last;
  logic                           s_lon;
  logic                           s_ron;
  logic                           s_mon;
  logic [tcbsg_pkg::CHAR_W-1:0]   s_lch;
  logic [tcbsg_pkg::CHAR_W-1:0]   s_mch;
  logic [tcbsg_pkg::CHAR_W-1:0]   s_rch;

  assign emit = (state == tcbsg_pkg::BK_RUN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcbsg_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      tcbsg_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = tcbsg_pkg::BK_RUN;
        end
      end
      tcbsg_pkg::BK_RUN: begin
        if (emit && is_last) begin
          state_next = tcbsg_pkg::BK_IDLE;
        end
      end
      default: state_next = tcbsg_pkg::BK_IDLE;
    endcase
  end

  // Load a box on pop, advance a row per emitted span
  always_ff @(posedge clk) begin
    if (q_pop) begin
      flags   <= q_flags;
      fc      <= q_char;
      cx1     <= q_cx1;
      cx2     <= q_cx2;
      cy1     <= q_cy1;
      cy2     <= q_cy2;
      cur_row <= q_cy1;
    end else if (emit) begin
      cur_row <= cur_row + RW'(1);
    end
  end

  always_comb begin
    is_top  = (cur_row == cy1) && !flags.tclip;
    is_bot  = (cur_row == cy2) && !flags.bclip;
    is_last = (cur_row == cy2);
    if (flags.cmd == tcbsg_pkg::CMD_FILL) begin
      s_lon = 1'b1;
      s_ron = 1'b1;
      s_mon = flags.mon;
      s_lch = fc;
      s_rch = fc;
      s_mch = flags.mon ? fc : '0;
    end else if (is_top || is_bot) begin
      s_lon = 1'b1;
      s_ron = 1'b1;
      s_mon = flags.mon;
      // Bottom corners win on a one-row box
      if (flags.lc_x2) begin
        s_lch = is_bot ? tcbsg_pkg::CH_QUOTE : tcbsg_pkg::CH_PERIOD;
      end else if (!flags.lclip) begin
        s_lch = is_bot ? tcbsg_pkg::CH_BACKTICK : tcbsg_pkg::CH_COMMA;
      end else begin
        s_lch = tcbsg_pkg::CH_DASH;
      end
      if (!flags.rclip) begin
        s_rch = is_bot ? tcbsg_pkg::CH_QUOTE : tcbsg_pkg::CH_PERIOD;
      end else if (flags.rc_x1) begin
        s_rch = is_bot ? tcbsg_pkg::CH_BACKTICK : tcbsg_pkg::CH_COMMA;
      end else begin
        s_rch = tcbsg_pkg::CH_DASH;
      end
      s_mch = flags.mon ? tcbsg_pkg::CH_DASH : '0;
    end else begin
      // Side bars; a clipped side writes nothing
      s_lon = !flags.lclip;
      s_ron = !flags.rclip;
      s_mon = 1'b0;
      s_lch = flags.lclip ? '0 : tcbsg_pkg::CH_BAR;
      s_rch = flags.rclip ? '0 : tcbsg_pkg::CH_BAR;
      s_mch = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row         <= ROW_OUT_W'(cur_row);
      left_col    <= COL_OUT_W'(cx1);
      right_col   <= COL_OUT_W'(cx2);
      left_on     <= s_lon;
      right_on    <= s_ron;
      middle_on   <= s_mon;
      left_char   <= s_lch;
      middle_char <= s_mch;
      right_char  <= s_rch;
      last_span   <= is_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/text_cell_box_span_generator_unit.sv
// Text cell box span generator, top level: config registers, front end,
// box queue and span engine. Uses tcbsg_pkg, tcbsg_front, tcbsg_queue, tcbsg_back.
//
// Usage: write screen_width (index 0) and screen_height (index 1) on the
// config channel while the block is idle; writes to other indexes are dropped.
// cfg_ready is always high. Each input transaction carries one box command
// with two corners in any order. A box with no visible cell gives no spans;
// otherwise one span per visible row comes out, top to bottom, with
// last_span set on the bottom one.
// Flow: the front end holds and classifies a box and pushes it into the
// queue, the span engine loads it, and each span is registered at the
// output (classify and queue, load, emit). The span engine takes the next
// box only after the last span of the current one and emits one span per
// cycle while the receiver keeps up, so throughput is set by the row walk;
// the front end takes a new command every cycle until the two-entry queue fills.
// A stalled receiver holds the output register and pauses the row walk; the
// queue and front end keep taking commands until full.
// Reset (synchronous): sets the screen to 80 x 25, empties the queue and
// drops any box in progress.
`default_nettype none

module text_cell_box_span_generator_unit #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tcbsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcbsg_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                command,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0] corner_a_x,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0] corner_a_y,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0] corner_b_x,
  input  wire logic signed [tcbsg_pkg::CORD_W-1:0] corner_b_y,
  input  wire logic [tcbsg_pkg::CHAR_W-1:0]        fill_char,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tcbsg_pkg::ROW_OUT_W-1:0]          row,
  output logic [tcbsg_pkg::COL_OUT_W-1:0]          left_col,
  output logic [tcbsg_pkg::COL_OUT_W-1:0]          right_col,
  output logic                                     left_on,
  output logic                                     right_on,
  output logic                                     middle_on,
  output logic [tcbsg_pkg::CHAR_W-1:0]             left_char,
  output logic [tcbsg_pkg::CHAR_W-1:0]             middle_char,
  output logic [tcbsg_pkg::CHAR_W-1:0]             right_char,
  output logic                                     last_span
);

  localparam int CW      = $clog2(MAX_COLUMNS);
  localparam int RW      = $clog2(MAX_ROWS);
  localparam int CHAR_W  = tcbsg_pkg::CHAR_W;
  localparam int FLAGS_W = tcbsg_pkg::FLAGS_W;
  localparam int QW      = FLAGS_W + CHAR_W + 2 * CW + 2 * RW;

  logic [tcbsg_pkg::WIDTH_W-1:0]  screen_width;
  logic [tcbsg_pkg::HEIGHT_W-1:0] screen_height;

  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  logic [QW-1:0]          q_wr;
  logic [QW-1:0]          q_rd;

  tcbsg_pkg::box_flags_t  f_flags;
  logic [CHAR_W-1:0]      f_char;
  logic [CW-1:0]          f_cx1;
  logic [CW-1:0]          f_cx2;
  logic [RW-1:0]          f_cy1;
  logic [RW-1:0]          f_cy2;

  tcbsg_pkg::box_flags_t  b_flags;
  logic [CHAR_W-1:0]      b_char;
  logic [CW-1:0]          b_cx1;
  logic [CW-1:0]          b_cx2;
  logic [RW-1:0]          b_cy1;
  logic [RW-1:0]          b_cy2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= tcbsg_pkg::RST_SCREEN_WIDTH;
      screen_height <= tcbsg_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcbsg_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        tcbsg_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[tcbsg_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  tcbsg_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .corner_a_x   (corner_a_x),
    .corner_a_y   (corner_a_y),
    .corner_b_x   (corner_b_x),
    .corner_b_y   (corner_b_y),
    .fill_char    (fill_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .box_flags    (f_flags),
    .box_char     (f_char),
    .box_cx1      (f_cx1),
    .box_cx2      (f_cx2),
    .box_cy1      (f_cy1),
    .box_cy2      (f_cy2)
  );

  assign q_wr = {f_flags, f_char, f_cx1, f_cx2, f_cy1, f_cy2};

  tcbsg_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  assign {b_flags, b_char, b_cx1, b_cx2, b_cy1, b_cy2} = q_rd;

  tcbsg_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_flags    (b_flags),
    .q_char     (b_char),
    .q_cx1      (b_cx1),
    .q_cx2      (b_cx2),
    .q_cy1      (b_cy1),
    .q_cy2      (b_cy2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row        (row),
    .left_col   (left_col),
    .right_col  (right_col),
    .left_on    (left_on),
    .right_on   (right_on),
    .middle_on  (middle_on),
    .left_char  (left_char),
    .middle_char(middle_char),
    .right_char (right_char),
    .last_span  (last_span)
  );

endmodule

`default_nettype wire
